>>> hw/rtl/vsap_pkg.sv
// package: item, configuration and state types and fixed constants of the alert packetizer
package vsap_pkg;

  localparam logic CMD_VITALS = 1'b0;
  localparam logic CMD_POWER  = 1'b1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HR_ALERT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HR_EMERGENCY  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPO2_ALERT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPO2_EMERGENCY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_ALERT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_EMERGENCY = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_MOTION   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTO_VERSION = 3'd7;

  localparam logic [7:0]         RST_HR_ALERT       = 8'd120;
  localparam logic [7:0]         RST_HR_EMERGENCY   = 8'd140;
  localparam logic [6:0]         RST_SPO2_ALERT     = 7'd92;
  localparam logic [6:0]         RST_SPO2_EMERGENCY = 7'd88;
  localparam logic signed [15:0] RST_TEMP_ALERT     = 16'sd3800;
  localparam logic signed [15:0] RST_TEMP_EMERGENCY = 16'sd3950;
  localparam logic [15:0]        RST_FALL_MOTION    = 16'd300;
  localparam logic [7:0]         RST_PROTO_VERSION  = 8'd1;

  localparam logic [15:0] LOW_BATT_MV      = 16'd3500;
  localparam logic [15:0] RECOVER_BATT_MV  = 16'd3600;
  localparam logic [31:0] NORMAL_PERIOD_MS = 32'd60000;
  localparam logic [7:0]  SPO2_MAX         = 8'd100;

  localparam int FLAG_ALERT   = 0;
  localparam int FLAG_EMERG   = 1;
  localparam int FLAG_LOWBATT = 2;

  typedef struct packed {
    logic        cmd;
    logic        sensor_ok;
    logic [7:0]  heart_rate;
    logic [7:0]  oxygen_sat;
    logic signed [15:0] skin_temp;
    logic [15:0] motion_rms;
    logic [31:0] now_ms;
    logic        battery_ok;
    logic [15:0] battery_mv;
    logic        charger_ok;
    logic        is_charging;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [2:0]  flags_byte;
    logic [7:0]  out_heart_rate;
    logic [6:0]  out_oxygen_sat;
    logic signed [15:0] out_skin_temp;
    logic [15:0] out_motion_rms;
    logic [7:0]  checksum;
    logic        send_now;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  hr_warn_bpm;
    logic [7:0]  hr_emergency_bpm;
    logic [6:0]  spo2_warn_pct;
    logic [6:0]  spo2_emergency_pct;
    logic signed [15:0] temp_alert_centi;
    logic signed [15:0] temp_emergency_centi;
    logic [15:0] fall_motion_threshold;
    logic [7:0]  protocol_version;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  held_heart_rate;
    logic [7:0]  held_oxygen_sat;
    logic [15:0] held_skin_temp;
    logic [15:0] held_motion_rms;
    logic [15:0] packet_counter;
    logic [31:0] last_normal_send_ms;
    logic        battery_low;
    logic        docked;
  } state_t;

  typedef struct packed {
    logic      has_result;
    out_item_t result;
    state_t    state_next;
  } eval_t;

endpackage

>>> hw/rtl/vsap_stream_if.sv
// interface: valid/ready channel carrying one item
interface vsap_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/vsap_cfg_regs.sv
// module: threshold and version configuration registers
module vsap_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [vsap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vsap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output vsap_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hr_warn_bpm           <= vsap_pkg::RST_HR_ALERT;
      cfg.hr_emergency_bpm      <= vsap_pkg::RST_HR_EMERGENCY;
      cfg.spo2_warn_pct         <= vsap_pkg::RST_SPO2_ALERT;
      cfg.spo2_emergency_pct    <= vsap_pkg::RST_SPO2_EMERGENCY;
      cfg.temp_alert_centi      <= vsap_pkg::RST_TEMP_ALERT;
      cfg.temp_emergency_centi  <= vsap_pkg::RST_TEMP_EMERGENCY;
      cfg.fall_motion_threshold <= vsap_pkg::RST_FALL_MOTION;
      cfg.protocol_version      <= vsap_pkg::RST_PROTO_VERSION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsap_pkg::REG_HR_ALERT:       cfg.hr_warn_bpm           <= cfg_wdata[7:0];
        vsap_pkg::REG_HR_EMERGENCY:   cfg.hr_emergency_bpm      <= cfg_wdata[7:0];
        vsap_pkg::REG_SPO2_ALERT:     cfg.spo2_warn_pct         <= cfg_wdata[6:0];
        vsap_pkg::REG_SPO2_EMERGENCY: cfg.spo2_emergency_pct    <= cfg_wdata[6:0];
        vsap_pkg::REG_TEMP_ALERT:     cfg.temp_alert_centi      <= $signed(cfg_wdata[15:0]);
        vsap_pkg::REG_TEMP_EMERGENCY: cfg.temp_emergency_centi  <= $signed(cfg_wdata[15:0]);
        vsap_pkg::REG_FALL_MOTION:    cfg.fall_motion_threshold <= cfg_wdata[15:0];
        vsap_pkg::REG_PROTO_VERSION:  cfg.protocol_version      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/vsap_eval.sv
// module: grading, packet assembly, checksum and next state for one item
module vsap_eval (
  input  vsap_pkg::in_item_t item,
  input  vsap_pkg::state_t   state,
  input  vsap_pkg::cfg_t     cfg,
  output vsap_pkg::eval_t    eval
);

  logic [7:0]  hr;
  logic [7:0]  spo2_raw;
  logic [6:0]  spo2;
  logic [15:0] traw;
  logic signed [15:0] temp;
  logic [15:0] motion;
  logic [2:0]  flags;
  logic        emerg_tier;
  logic        alert_tier;
  logic [31:0] elapsed;
  logic        normal_due;
  logic [7:0]  sum;

  always_comb begin
    hr       = item.sensor_ok ? item.heart_rate : state.held_heart_rate;
    spo2_raw = item.sensor_ok ? item.oxygen_sat : state.held_oxygen_sat;
    traw     = item.sensor_ok ? item.skin_temp  : state.held_skin_temp;
    motion   = item.sensor_ok ? item.motion_rms : state.held_motion_rms;
    spo2     = (spo2_raw > vsap_pkg::SPO2_MAX) ? vsap_pkg::SPO2_MAX[6:0] : spo2_raw[6:0];
    temp     = $signed(traw);

    emerg_tier = (hr >= cfg.hr_emergency_bpm) || (spo2 <= cfg.spo2_emergency_pct)
                 || (temp >= cfg.temp_emergency_centi);
    alert_tier = (hr >= cfg.hr_warn_bpm) || (spo2 <= cfg.spo2_warn_pct)
                 || (temp >= cfg.temp_alert_centi);

    flags = '0;
    if (emerg_tier) begin
      flags[vsap_pkg::FLAG_EMERG] = 1'b1;
    end else if (alert_tier) begin
      flags[vsap_pkg::FLAG_ALERT] = 1'b1;
    end
    if (motion >= cfg.fall_motion_threshold) begin
      flags[vsap_pkg::FLAG_EMERG] = 1'b1;
    end
    flags[vsap_pkg::FLAG_LOWBATT] = state.battery_low;

    elapsed    = item.now_ms - state.last_normal_send_ms;
    normal_due = (elapsed >= vsap_pkg::NORMAL_PERIOD_MS);

    // byte sum wraps at 8 bits
    sum = cfg.protocol_version
        + state.packet_counter[7:0] + state.packet_counter[15:8]
        + item.now_ms[7:0] + item.now_ms[15:8] + item.now_ms[23:16] + item.now_ms[31:24]
        + {5'd0, flags} + hr + {1'b0, spo2}
        + traw[7:0] + traw[15:8] + motion[7:0] + motion[15:8];

    eval.state_next = state;
    eval.has_result = 1'b0;

    eval.result.sequence_res   = state.packet_counter;
    eval.result.timestamp      = item.now_ms;
    eval.result.flags_byte     = flags;
    eval.result.out_heart_rate = hr;
    eval.result.out_oxygen_sat = spo2;
    eval.result.out_skin_temp  = temp;
    eval.result.out_motion_rms = motion;
    eval.result.checksum       = sum;
    eval.result.send_now       = flags[vsap_pkg::FLAG_ALERT] || flags[vsap_pkg::FLAG_EMERG]
                                 || normal_due;

    if (item.cmd == vsap_pkg::CMD_POWER) begin
      if (item.battery_ok) begin
        priority if (!state.battery_low && item.battery_mv <= vsap_pkg::LOW_BATT_MV) begin
          eval.state_next.battery_low = 1'b1;
        end else if (state.battery_low && item.battery_mv >= vsap_pkg::RECOVER_BATT_MV) begin
          eval.state_next.battery_low = 1'b0;
        end else begin
          eval.state_next.battery_low = state.battery_low;
        end
      end
      if (item.charger_ok) begin
        eval.state_next.docked = item.is_charging;
      end
    end else if (!state.docked) begin
      eval.has_result = 1'b1;
      eval.state_next.held_heart_rate = hr;
      eval.state_next.held_oxygen_sat = spo2_raw;
      eval.state_next.held_skin_temp  = traw;
      eval.state_next.held_motion_rms = motion;
      eval.state_next.packet_counter  = state.packet_counter + 16'd1;
      if (!(flags[vsap_pkg::FLAG_ALERT] || flags[vsap_pkg::FLAG_EMERG]) && normal_due) begin
        eval.state_next.last_normal_send_ms = item.now_ms;
      end
    end
  end

endmodule

>>> hw/rtl/vital_sign_alert_packetizer.sv
// top level: input register, state, evaluation and result register of the alert packetizer
//
// Takes one item per clock cycle. For a vitals sample while not docked, the packet passes
// from the input register to the result register: the item waits in the input register
// while the grading and checksum logic feeds the result register, which loads the packet as
// the item leaves. Power polls and vitals samples taken while docked give no packet. All
// state is updated in the cycle an item leaves the input register, so the next item follows
// at once; a waiting packet stalls the input only while its sink is not ready and the item
// in the input register also makes a packet.
module vital_sign_alert_packetizer (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [vsap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vsap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  vsap_stream_if.sink   in_ch,
  vsap_stream_if.source out_ch
);

  vsap_pkg::cfg_t     cfg;
  vsap_pkg::state_t   state;
  vsap_pkg::eval_t    eval;
  vsap_pkg::in_item_t in_item;
  vsap_pkg::out_item_t out_item;
  logic in_valid;
  logic out_valid;
  logic advance;
  logic out_load;

  vsap_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vsap_eval u_eval (
    .item  (in_item),
    .state (state),
    .cfg   (cfg),
    .eval  (eval)
  );

  assign advance  = in_valid && (!eval.has_result || !out_valid || out_ch.ready);
  assign out_load = advance && eval.has_result;

  assign in_ch.ready    = !in_valid || advance;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item <= in_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= eval.state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= eval.result;
    end
  end

  // a packet never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ch.ready))
    else $error("result overwritten while stalled");

  // sequence advances by one per packet and holds otherwise
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (state.packet_counter ==
              ($past(out_load) ? $past(state.packet_counter) + 16'd1
                               : $past(state.packet_counter))))
    else $error("sequence number out of step");

  // alert and emergency packets are always marked to send
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.flags_byte[vsap_pkg::FLAG_ALERT]
                  || out_item.flags_byte[vsap_pkg::FLAG_EMERG]) |-> out_item.send_now)
    else $error("graded packet not marked to send");

  // vitals taken while docked produce no packet
  assert property (@(posedge clk) disable iff (rst)
    advance && state.docked && (in_item.cmd == vsap_pkg::CMD_VITALS) |-> !out_load)
    else $error("packet emitted while docked");

endmodule
